[hw/rtl/stxrx_pkg.sv]
// Shared types and constants for the serial transmit and receive ring buffers.
package stxrx_pkg;

  // Operation codes carried in the mode field of an input transaction.
  typedef enum logic [2:0] {
    MODE_TX_PUSH   = 3'd0,
    MODE_TX_POP    = 3'd1,
    MODE_RX_PUSH   = 3'd2,
    MODE_RX_POP    = 3'd3,
    MODE_LINE_DONE = 3'd4
  } mode_t;

  // Character codes the receive path treats specially.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Status one ring reports to the top level for the current transaction.
  typedef struct packed {
    logic pending;   // Ring holds at least one byte after this transaction.
    logic pop_hit;   // A pop found data; read data is valid next cycle.
  } ring_status_t;

endpackage

[hw/rtl/stxrx_ring.sv]
// Circular byte buffer with a synchronous memory and pointer logic.
module stxrx_ring
  import stxrx_pkg::*;
#(
  parameter int DEPTH     = 32,
  parameter bit OVERWRITE = 1'b0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic         pop,
  input  logic [7:0]   wdata,
  output logic [7:0]   rdata,
  output ring_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr_next;
  logic [AW-1:0] rd_ptr_next;
  logic [AW-1:0] wr_inc;
  logic [AW-1:0] rd_inc;
  logic          full;
  logic          empty;
  logic          do_write;
  logic          do_read;

  // Pointer increments wrap at the buffer depth, which need not be a power of two.
  assign wr_inc = (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_inc = (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
  assign full   = (wr_inc == rd_ptr);
  assign empty  = (wr_ptr == rd_ptr);

  // A full buffer either drops the new byte or drops its oldest byte.
  assign do_write = push && (OVERWRITE || !full);
  assign do_read  = pop && !empty;

  always_comb begin
    wr_ptr_next = do_write ? wr_inc : wr_ptr;
    if (do_read || (do_write && full)) begin
      rd_ptr_next = rd_inc;
    end else begin
      rd_ptr_next = rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  // Storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_ptr] <= wdata;
    end
    if (do_read) begin
      rdata <= mem[rd_ptr];
    end
  end

  assign status.pending = (wr_ptr_next != rd_ptr_next);
  assign status.pop_hit = do_read;

endmodule

[hw/rtl/serial_tx_rx_ring_buffers_unit.sv]
// Top level of the serial transmit and receive ring buffers with line counting.
// Each result is registered in the output stage and appears in the cycle after its input is accepted.
// Throughput: one transaction per cycle while the output is not stalled; each ring memory does one access per cycle.
// The output stage holds the result while stalled and the input then stalls too.
// Synchronous reset empties both rings, clears the line count and the output valid.
// Buffer contents are not cleared; a ring never reads an entry it has not written.
module serial_tx_rx_ring_buffers_unit
  import stxrx_pkg::*;
#(
  parameter int TX_DEPTH = 128,
  parameter int RX_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] mode,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic       tx_pending,
  output logic [7:0] line_count,
  output logic       line_event
);

  logic         accept;
  logic         tx_push;
  logic         tx_pop;
  logic         rx_push;
  logic         rx_pop;
  logic         line_done;
  logic [7:0]   rx_byte;
  logic         rx_is_lf;
  logic [7:0]   line_count_next;
  logic [7:0]   tx_rdata;
  logic [7:0]   rx_rdata;
  ring_status_t tx_status;
  ring_status_t rx_status;
  logic         sel_tx;
  logic         sel_rx;

  // The input stalls only while a finished result waits at the output.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Decode the operation of the accepted transaction.
  always_comb begin
    tx_push   = 1'b0;
    tx_pop    = 1'b0;
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    line_done = 1'b0;
    if (accept) begin
      unique case (mode)
        MODE_TX_PUSH:   tx_push   = 1'b1;
        MODE_TX_POP:    tx_pop    = 1'b1;
        MODE_RX_PUSH:   rx_push   = (byte_in != CH_NUL);
        MODE_RX_POP:    rx_pop    = 1'b1;
        MODE_LINE_DONE: line_done = 1'b1;
        default:        ;
      endcase
    end
  end

  // Carriage return is stored as line feed.
  assign rx_byte  = (byte_in == CH_CR) ? CH_LF : byte_in;
  assign rx_is_lf = (rx_byte == CH_LF);

  // Line count wraps on increment and saturates at zero on decrement.
  always_comb begin
    line_count_next = line_count;
    if (rx_push && rx_is_lf) begin
      line_count_next = line_count + 8'd1;
    end else if (line_done && (line_count != 8'd0)) begin
      line_count_next = line_count - 8'd1;
    end
  end

  stxrx_ring #(
    .DEPTH     (TX_DEPTH),
    .OVERWRITE (1'b0)
  ) u_tx_ring (
    .clk    (clk),
    .rst    (rst),
    .push   (tx_push),
    .pop    (tx_pop),
    .wdata  (byte_in),
    .rdata  (tx_rdata),
    .status (tx_status)
  );

  stxrx_ring #(
    .DEPTH     (RX_DEPTH),
    .OVERWRITE (1'b1)
  ) u_rx_ring (
    .clk    (clk),
    .rst    (rst),
    .push   (rx_push),
    .pop    (rx_pop),
    .wdata  (rx_byte),
    .rdata  (rx_rdata),
    .status (rx_status)
  );

  // Output stage: loads on every accepted transaction and holds while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      tx_pending <= 1'b0;
      line_count <= '0;
      line_event <= 1'b0;
      sel_tx     <= 1'b0;
      sel_rx     <= 1'b0;
    end else begin
      if (accept) begin
        out_valid  <= 1'b1;
        tx_pending <= tx_status.pending;
        line_count <= line_count_next;
        line_event <= rx_push && rx_is_lf;
        sel_tx     <= tx_status.pop_hit;
        sel_rx     <= rx_status.pop_hit && !rx_status.pending ? 1'b1 : rx_status.pop_hit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The popped byte comes straight from the ring's registered read data.
  assign byte_out = sel_tx ? tx_rdata : (sel_rx ? rx_rdata : 8'd0);

endmodule

[hw/rtl/stxrx_checker.sv]
// Port-level checks for the serial ring buffers, bound to the top level.
module stxrx_checker
  import stxrx_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] mode,
  input logic [7:0] byte_in,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] byte_out,
  input logic       tx_pending,
  input logic [7:0] line_count,
  input logic       line_event
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_out) && $stable(line_count))
    else $error("stalled result changed");

  // A line event only comes from a receive push, which never returns a byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && line_event |-> byte_out == 8'd0)
    else $error("line event with nonzero byte");

  // A received NUL is dropped and raises no line event.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_RX_PUSH && byte_in == CH_NUL
      |=> out_valid && !line_event)
    else $error("NUL caused a line event");

  // After a transmit push the transmit buffer is never empty.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_TX_PUSH |=> out_valid && tx_pending)
    else $error("tx push left buffer empty");

  // Line done never returns data and never raises a line event.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_LINE_DONE
      |=> out_valid && byte_out == 8'd0 && !line_event)
    else $error("line done produced data");

endmodule

bind serial_tx_rx_ring_buffers_unit stxrx_checker u_stxrx_checker (.*);

[verif/stxrx_ring_checker.sv]
// Checker that predicts and compares the results of the serial ring buffer unit.
module stxrx_ring_checker
  import stxrx_pkg::*;
#(
  parameter int TX_DEPTH = 128,
  parameter int RX_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] mode,
  input  logic [7:0] byte_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] byte_out,
  input  logic       tx_pending,
  input  logic [7:0] line_count,
  input  logic       line_event,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] byte_val;
    logic       pending;
    logic [7:0] lines;
    logic       line_ev;
  } ring_result_t;

  // Shadow copy of both rings and the line counter.
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  int         tx_wr;
  int         tx_rd;
  int         rx_wr;
  int         rx_rd;
  logic [7:0] lines_waiting;

  ring_result_t predicted_outputs [$];

  // Applies one input transaction to the shadow rings and returns its result.
  task automatic predict_ring_step(input logic [2:0] op, input logic [7:0] data,
                                   output ring_result_t res);
    logic [7:0] ch;
    res = '0;
    ch  = data;
    case (op)
      MODE_TX_PUSH: begin
        // A full transmit ring drops the new byte.
        if ((tx_wr + 1) % TX_DEPTH != tx_rd) begin
          tx_mem[tx_wr] = data;
          tx_wr = (tx_wr + 1) % TX_DEPTH;
        end
      end
      MODE_TX_POP: begin
        if (tx_wr != tx_rd) begin
          res.byte_val = tx_mem[tx_rd];
          tx_rd = (tx_rd + 1) % TX_DEPTH;
        end
      end
      MODE_RX_PUSH: begin
        // NUL is ignored, CR is stored as LF, and an overflow drops the oldest byte.
        if (ch != CH_NUL) begin
          if (ch == CH_CR) ch = CH_LF;
          rx_mem[rx_wr] = ch;
          rx_wr = (rx_wr + 1) % RX_DEPTH;
          if (rx_wr == rx_rd) rx_rd = (rx_rd + 1) % RX_DEPTH;
          if (ch == CH_LF) begin
            lines_waiting = lines_waiting + 8'd1;
            res.line_ev = 1'b1;
          end
        end
      end
      MODE_RX_POP: begin
        if (rx_wr != rx_rd) begin
          res.byte_val = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % RX_DEPTH;
        end
      end
      MODE_LINE_DONE: begin
        if (lines_waiting != 8'd0) lines_waiting = lines_waiting - 8'd1;
      end
      default: ;
    endcase
    res.pending = (tx_wr != tx_rd);
    res.lines   = lines_waiting;
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    fail_count++;
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  // Output transactions are compared before the input of the same edge is predicted,
  // since a result always belongs to an earlier input.
  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    if (rst) begin
      tx_wr         = 0;
      tx_rd         = 0;
      rx_wr         = 0;
      rx_rd         = 0;
      lines_waiting = 8'd0;
      fail_count    = 0;
      predicted_outputs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{byte_out, tx_pending, line_count, line_event};
        if (predicted_outputs.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none, got 0x%0h", $time, got);
        end else begin
          want = predicted_outputs.pop_front();
          if (got.byte_val != want.byte_val)
            note_mismatch("byte_out", int'(want.byte_val), int'(got.byte_val));
          if (got.pending != want.pending)
            note_mismatch("tx_pending", int'(want.pending), int'(got.pending));
          if (got.lines != want.lines)
            note_mismatch("line_count", int'(want.lines), int'(got.lines));
          if (got.line_ev != want.line_ev)
            note_mismatch("line_event", int'(want.line_ev), int'(got.line_ev));
        end
      end
      if (in_valid && !in_stall) begin
        predict_ring_step(mode, byte_in, want);
        predicted_outputs.push_back(want);
      end
    end
    outstanding <= predicted_outputs.size();
  end

endmodule

[verif/testbench.sv]
// Top of the testbench: stimulus, receiver stalls, watchdog and verdict.
module testbench;
  import stxrx_pkg::*;

  localparam int         IDLE_LIMIT     = 1000;
  localparam int         MAX_BURST      = 18;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [2:0] mode      = MODE_TX_PUSH;
  logic [7:0] byte_in   = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] byte_out;
  logic       tx_pending;
  logic [7:0] line_count;
  logic       line_event;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  serial_tx_rx_ring_buffers_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_out   (byte_out),
    .tx_pending (tx_pending),
    .line_count (line_count),
    .line_event (line_event)
  );

  stxrx_ring_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .byte_in     (byte_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_out    (byte_out),
    .tx_pending  (tx_pending),
    .line_count  (line_count),
    .line_event  (line_event),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Presents one input transaction, sometimes after a burst of idle cycles,
  // and returns once it has been accepted.
  task automatic send_transaction(input logic [2:0] op, input logic [7:0] data);
    int gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, MAX_BURST);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    byte_in  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends a run of random transactions with the given mix of operations.
  // In a line flood every received byte is a line terminator.
  task automatic run_phase(input int items, input int w_tx_push, input int w_tx_pop,
                           input int w_rx_push, input int w_rx_pop, input int w_done,
                           input int w_unused, input bit line_flood);
    int         total;
    int         pick;
    int         r;
    logic [2:0] op;
    logic [7:0] data;
    total = w_tx_push + w_tx_pop + w_rx_push + w_rx_pop + w_done + w_unused;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, total - 1);
      if (pick < w_tx_push) op = MODE_TX_PUSH;
      else if (pick < w_tx_push + w_tx_pop) op = MODE_TX_POP;
      else if (pick < w_tx_push + w_tx_pop + w_rx_push) op = MODE_RX_PUSH;
      else if (pick < w_tx_push + w_tx_pop + w_rx_push + w_rx_pop) op = MODE_RX_POP;
      else if (pick < total - w_unused) op = MODE_LINE_DONE;
      else op = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      data = 8'($urandom_range(0, 255));
      // Received text leans on the characters the receive path treats specially.
      if (op == MODE_RX_PUSH) begin
        r = $urandom_range(0, 99);
        if (line_flood) data = $urandom_range(0, 1) ? CH_CR : CH_LF;
        else if (r < 10) data = CH_CR;
        else if (r < 20) data = CH_LF;
        else if (r < 25) data = CH_NUL;
        else if (r < 65) data = 8'($urandom_range(8'h20, 8'h7E));
      end
      send_transaction(op, data);
    end
  endtask

  // Receiver stalls come in random bursts.
  initial begin
    int len;
    forever begin
      @(posedge clk);
      if (!rst && $urandom_range(0, 99) < stall_pct) begin
        len = $urandom_range(1, MAX_BURST);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main stimulus and verdict.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty pops, data extremes, NUL, CR, LF and unused modes.
    gap_pct   = 8;
    stall_pct = 6;
    send_transaction(MODE_TX_POP, 8'hFF);
    send_transaction(MODE_RX_POP, 8'hFF);
    send_transaction(MODE_LINE_DONE, 8'h00);
    send_transaction(MODE_TX_PUSH, 8'h00);
    send_transaction(MODE_TX_PUSH, 8'hFF);
    send_transaction(MODE_TX_POP, 8'h00);
    send_transaction(MODE_TX_POP, 8'h00);
    send_transaction(MODE_TX_POP, 8'h00);
    send_transaction(MODE_RX_PUSH, CH_NUL);
    send_transaction(MODE_RX_PUSH, 8'hFF);
    send_transaction(MODE_RX_PUSH, CH_CR);
    send_transaction(MODE_RX_PUSH, CH_LF);
    send_transaction(MODE_RX_PUSH, 8'h41);
    send_transaction(MODE_RX_POP, 8'h00);
    send_transaction(MODE_RX_POP, 8'h00);
    send_transaction(MODE_LINE_DONE, 8'hFF);
    send_transaction(MODE_UNUSED_LO, 8'hFF);
    send_transaction(MODE_UNUSED_LO + 3'd1, 8'h55);
    send_transaction(MODE_UNUSED_HI, 8'hAA);
    send_transaction(MODE_LINE_DONE, 8'h00);
    send_transaction(MODE_LINE_DONE, 8'h00);
    send_transaction(MODE_RX_POP, 8'h00);
    send_transaction(MODE_RX_POP, 8'h00);
    send_transaction(MODE_RX_POP, 8'h00);

    // Random part, shaped to fill and drain the transmit ring, overflow the
    // receive ring and wrap the line count.
    run_phase(100, 25, 20, 25, 15, 10, 5, 1'b0);
    gap_pct   = 0;
    stall_pct = 0;
    run_phase(160, 90, 5, 3, 0, 0, 2, 1'b0);
    gap_pct   = 15;
    stall_pct = 10;
    run_phase(140, 15, 80, 0, 0, 0, 5, 1'b0);
    gap_pct   = 5;
    stall_pct = 3;
    run_phase(130, 5, 5, 60, 15, 15, 0, 1'b0);
    gap_pct   = 4;
    stall_pct = 8;
    run_phase(280, 0, 0, 97, 0, 0, 3, 1'b1);

    // Closing stretch runs at full rate on both sides.
    gap_pct   = 0;
    stall_pct = 0;
    run_phase(50, 20, 20, 20, 20, 15, 5, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
